// ===== hdl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, status codes and the sequencer control store for the
// binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;
	localparam int UPC_W    = 4;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// read address source
	typedef enum logic [2:0] {
		RA_ZERO,
		RA_LAST,
		RA_PARENT,
		RA_LEFT,
		RA_RIGHT
	} addr_sel_t;

	// datapath action, performed only when the step condition holds
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_INS_INIT,
		ACT_MOVE_UP,
		ACT_TAKE_ROOT,
		ACT_LOAD_CUR,
		ACT_LOAD_LEFT,
		ACT_LOAD_RIGHT,
		ACT_MOVE_DOWN,
		ACT_FINISH
	} act_t;

	// step condition; when true the action runs and the step counter jumps
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_POS_ZERO,
		C_PARENT_LT,
		C_NO_LEFT,
		C_NO_SWAP
	} cond_t;

	typedef struct packed {
		addr_sel_t        rd_sel;
		act_t             act;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	// program entry points
	localparam logic [UPC_W-1:0] UPC_INS     = 4'd0;
	localparam logic [UPC_W-1:0] UPC_UP_LOOP = 4'd1;
	localparam logic [UPC_W-1:0] UPC_REM     = 4'd4;
	localparam logic [UPC_W-1:0] UPC_DN_LOOP = 4'd7;

	// signed key compare: a < b
	function automatic logic key_less(input logic [VALUE_W-1:0] a,
	                                  input logic [VALUE_W-1:0] b);
		key_less = $signed(a) < $signed(b);
	endfunction

	// control store
	function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
		uword_t w;
		w = '{RA_ZERO, ACT_FINISH, C_ALWAYS, UPC_INS};
		unique case (upc)
			// insert: open a slot at the end, then walk the hole upward
			4'd0:  w = '{RA_ZERO,   ACT_INS_INIT,   C_ALWAYS,    4'd1};
			4'd1:  w = '{RA_PARENT, ACT_FINISH,     C_POS_ZERO,  4'd0};
			4'd2:  w = '{RA_ZERO,   ACT_MOVE_UP,    C_PARENT_LT, UPC_UP_LOOP};
			4'd3:  w = '{RA_ZERO,   ACT_FINISH,     C_ALWAYS,    4'd0};
			// removal: take the root, pull the last entry, walk the hole down
			4'd4:  w = '{RA_ZERO,   ACT_NOP,        C_ALWAYS,    4'd5};
			4'd5:  w = '{RA_LAST,   ACT_TAKE_ROOT,  C_ALWAYS,    4'd6};
			4'd6:  w = '{RA_ZERO,   ACT_LOAD_CUR,   C_ALWAYS,    UPC_DN_LOOP};
			4'd7:  w = '{RA_LEFT,   ACT_FINISH,     C_NO_LEFT,   4'd0};
			4'd8:  w = '{RA_RIGHT,  ACT_LOAD_LEFT,  C_ALWAYS,    4'd9};
			4'd9:  w = '{RA_ZERO,   ACT_LOAD_RIGHT, C_ALWAYS,    4'd10};
			4'd10: w = '{RA_ZERO,   ACT_FINISH,     C_NO_SWAP,   4'd0};
			4'd11: w = '{RA_ZERO,   ACT_MOVE_DOWN,  C_ALWAYS,    UPC_DN_LOOP};
			default: w = '{RA_ZERO, ACT_FINISH,     C_ALWAYS,    UPC_INS};
		endcase
		ucode = w;
	endfunction

endpackage

// ===== hdl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys run by a microcoded step sequencer
// over a single-port-read entry memory.
// ----------------------------------------------------------------------------
// Operation: insert opens a slot at the end and climbs one level per parent
//   read until the key reaches the root or its parent is not smaller; removal
//   takes the root, pulls the last entry and descends until the hole has no left
//   child or no child is larger; overflow and underflow report in the cycle
//   after accept. Each sift level costs one memory read per child or parent, so
//   the read port paces the loop. Throughput: one transaction at a time, busy is
//   high while sifting. Reset: entry count clears to zero; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    command,
	input  logic signed [mhpq_pkg::VALUE_W-1:0]     item_value,
	output logic                                    done,
	output logic [mhpq_pkg::STATUS_W-1:0]           status,
	output logic signed [mhpq_pkg::VALUE_W-1:0]     result_value,
	output logic [mhpq_pkg::OCC_W-1:0]              occupancy
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = IW + 2;
	localparam int UW = mhpq_pkg::UPC_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

	// control state
	logic                            busy_q;
	logic                            done_q;
	logic [mhpq_pkg::STATUS_W-1:0]   status_q;
	logic [mhpq_pkg::UPC_W-1:0]      upc_q;
	logic [CW-1:0]                   count_q;

	// datapath registers
	logic [IW-1:0]                   pos_q;
	logic [IW-1:0]                   bidx_q;
	logic [mhpq_pkg::VALUE_W-1:0]    cur_q;
	logic [mhpq_pkg::VALUE_W-1:0]    bval_q;
	logic [mhpq_pkg::VALUE_W-1:0]    res_q;
	logic                            lsel_q;

	mhpq_pkg::uword_t                uw;
	logic                            taken;
	logic                            fire;
	logic                            accept;
	logic                            full;
	logic                            empty;
	logic [IW-1:0]                   pos_m1;
	logic [IW-1:0]                   parent_idx;
	logic [IW-1:0]                   last_idx;
	logic [XW-1:0]                   left_x;
	logic [XW-1:0]                   right_x;
	logic                            left_ok;
	logic                            right_ok;
	logic [mhpq_pkg::VALUE_W-1:0]    best_val;
	logic [IW-1:0]                   raddr;
	logic [mhpq_pkg::VALUE_W-1:0]    rdata;
	logic                            we;
	logic [mhpq_pkg::VALUE_W-1:0]    wdata;

	// fetch control word
	assign uw = mhpq_pkg::ucode(upc_q);

	assign accept = start && !busy_q;
	assign full   = (count_q == FULL_COUNT);
	assign empty  = (count_q == '0);

	// index arithmetic
	assign pos_m1     = pos_q - IW'(1);
	assign parent_idx = pos_m1 >> 1;
	assign last_idx   = IW'(count_q - CW'(1));
	assign left_x     = {1'b0, pos_q, 1'b1};
	assign right_x    = left_x + XW'(1);
	assign left_ok    = left_x < XW'(count_q);
	assign right_ok   = right_x < XW'(count_q);
	assign best_val   = lsel_q ? bval_q : cur_q;

	// evaluate step condition
	always_comb begin
		unique case (uw.cond)
			mhpq_pkg::C_ALWAYS:    taken = 1'b1;
			mhpq_pkg::C_POS_ZERO:  taken = (pos_q == '0);
			mhpq_pkg::C_PARENT_LT: taken = mhpq_pkg::key_less(rdata, cur_q);
			mhpq_pkg::C_NO_LEFT:   taken = !left_ok;
			mhpq_pkg::C_NO_SWAP:   taken = !lsel_q;
			default:               taken = 1'b0;
		endcase
	end

	assign fire = busy_q && taken;

	// select read address
	always_comb begin
		unique case (uw.rd_sel)
			mhpq_pkg::RA_ZERO:   raddr = '0;
			mhpq_pkg::RA_LAST:   raddr = last_idx;
			mhpq_pkg::RA_PARENT: raddr = parent_idx;
			mhpq_pkg::RA_LEFT:   raddr = IW'(left_x);
			mhpq_pkg::RA_RIGHT:  raddr = IW'(right_x);
			default:             raddr = '0;
		endcase
	end

	// write back into the hole at pos
	always_comb begin
		we    = 1'b0;
		wdata = cur_q;
		case (uw.act)
			mhpq_pkg::ACT_FINISH: begin
				we    = fire;
				wdata = cur_q;
			end
			mhpq_pkg::ACT_MOVE_UP: begin
				we    = fire;
				wdata = rdata;
			end
			mhpq_pkg::ACT_MOVE_DOWN: begin
				we    = fire;
				wdata = bval_q;
			end
			default: begin
				we    = 1'b0;
				wdata = cur_q;
			end
		endcase
	end

	mhpq_store #(
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (pos_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer, count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= mhpq_pkg::ST_OK;
			upc_q    <= mhpq_pkg::UPC_INS;
			count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (command == mhpq_pkg::CMD_INSERT) begin
					if (full) begin
						done_q   <= 1'b1;
						status_q <= mhpq_pkg::ST_OVERFLOW;
					end else begin
						busy_q <= 1'b1;
						upc_q  <= mhpq_pkg::UPC_INS;
					end
				end else begin
					if (empty) begin
						done_q   <= 1'b1;
						status_q <= mhpq_pkg::ST_UNDERFLOW;
					end else begin
						busy_q <= 1'b1;
						upc_q  <= mhpq_pkg::UPC_REM;
					end
				end
			end else if (busy_q) begin
				upc_q <= fire ? uw.target : upc_q + UW'(1);
				if (fire) begin
					case (uw.act)
						mhpq_pkg::ACT_INS_INIT:  count_q <= count_q + CW'(1);
						mhpq_pkg::ACT_TAKE_ROOT: count_q <= count_q - CW'(1);
						mhpq_pkg::ACT_FINISH: begin
							busy_q   <= 1'b0;
							done_q   <= 1'b1;
							status_q <= mhpq_pkg::ST_OK;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= item_value;
			res_q <= (command == mhpq_pkg::CMD_INSERT && !full) ? item_value : '0;
		end else if (fire) begin
			case (uw.act)
				mhpq_pkg::ACT_INS_INIT:  pos_q <= IW'(count_q);
				mhpq_pkg::ACT_MOVE_UP:   pos_q <= parent_idx;
				mhpq_pkg::ACT_TAKE_ROOT: res_q <= rdata;
				mhpq_pkg::ACT_LOAD_CUR: begin
					cur_q <= rdata;
					pos_q <= '0;
				end
				mhpq_pkg::ACT_LOAD_LEFT: begin
					bval_q <= rdata;
					bidx_q <= IW'(left_x);
					lsel_q <= mhpq_pkg::key_less(cur_q, rdata);
				end
				mhpq_pkg::ACT_LOAD_RIGHT: begin
					if (right_ok && mhpq_pkg::key_less(best_val, rdata)) begin
						bval_q <= rdata;
						bidx_q <= IW'(right_x);
						lsel_q <= 1'b1;
					end
				end
				mhpq_pkg::ACT_MOVE_DOWN: pos_q <= bidx_q;
				default: ;
			endcase
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign status       = status_q;
	assign result_value = res_q;
	assign occupancy    = mhpq_pkg::OCC_W'(count_q);

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above capacity");

	// a finished sift always raises the result strobe
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("sequencer finished without a result");

	// overflow only when full
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == mhpq_pkg::ST_OVERFLOW) |-> full)
		else $error("overflow reported while not full");

	// underflow only when empty
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == mhpq_pkg::ST_UNDERFLOW) |-> empty)
		else $error("underflow reported while not empty");

endmodule

// ===== hdl/mhpq_store.sv =====
// ----------------------------------------------------------------------------
// mhpq_store
// Heap entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhpq_store #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(DEPTH)-1:0]            waddr,
	input  logic [mhpq_pkg::VALUE_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0]            raddr,
	output logic [mhpq_pkg::VALUE_W-1:0]        rdata
);

	logic [mhpq_pkg::VALUE_W-1:0] mem_q [DEPTH];
	logic [mhpq_pkg::VALUE_W-1:0] rdata_q;

	// write entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read entry, data valid next cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-heap priority queue. A driver issues insert
// and remove-max transactions in random bursts, a heap predictor tracks the
// expected status, value and occupancy, and a monitor checks every done
// strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int HEAP_DEPTH  = 64;
	localparam int RANDOM_OPS  = 1600;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 60;
	localparam int KEY_W       = mhpq_pkg::VALUE_W;

	typedef struct {
		logic                cmd;
		logic [KEY_W-1:0]    key;
		bit                  drain_first;
	} heap_op_t;

	typedef struct {
		logic [mhpq_pkg::STATUS_W-1:0] status;
		logic [KEY_W-1:0]              value;
		logic [mhpq_pkg::OCC_W-1:0]    occupancy;
	} heap_result_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            command = mhpq_pkg::CMD_INSERT;
	logic signed [KEY_W-1:0]         item_value = '0;
	logic                            busy;
	logic                            done;
	logic [mhpq_pkg::STATUS_W-1:0]   status;
	logic signed [KEY_W-1:0]         result_value;
	logic [mhpq_pkg::OCC_W-1:0]      occupancy;

	heap_op_t          pending_ops[$];
	heap_result_t      expected_results[$];
	logic [KEY_W-1:0]  heap_keys[HEAP_DEPTH];
	int unsigned       heap_count = 0;
	int unsigned       error_count = 0;
	int unsigned       idle_cycles = 0;
	bit                timed_out = 1'b0;

	max_heap_priority_queue #(
		.MAX_ENTRIES(HEAP_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.item_value(item_value),
		.done(done),
		.status(status),
		.result_value(result_value),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// swap two heap slots in the predictor
	function automatic void swap_keys(input int unsigned a, input int unsigned b);
		logic [KEY_W-1:0] tmp;
		tmp = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = tmp;
	endfunction

	// apply one transaction to the predicted heap and return its result
	function automatic heap_result_t heap_apply(input logic cmd, input logic [KEY_W-1:0] key);
		heap_result_t r;
		int unsigned  pos;
		int unsigned  up;
		int unsigned  best;
		int unsigned  lft;
		int unsigned  rgt;
		r.status = mhpq_pkg::ST_OK;
		r.value  = '0;
		if (cmd == mhpq_pkg::CMD_INSERT) begin
			if (heap_count >= HEAP_DEPTH) begin
				r.status = mhpq_pkg::ST_OVERFLOW;
			end else begin
				heap_keys[heap_count] = key;
				pos = heap_count;
				heap_count++;
				// climb while the parent is strictly smaller
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!($signed(heap_keys[up]) < $signed(heap_keys[pos])))
						break;
					swap_keys(pos, up);
					pos = up;
				end
				r.value = key;
			end
		end else begin
			if (heap_count == 0) begin
				r.status = mhpq_pkg::ST_UNDERFLOW;
			end else begin
				r.value = heap_keys[0];
				heap_keys[0] = heap_keys[heap_count - 1];
				heap_count--;
				pos = 0;
				// descend toward the strictly larger child, left wins a tie
				while (pos < heap_count) begin
					best = pos;
					lft  = 2 * pos + 1;
					rgt  = 2 * pos + 2;
					if (lft < heap_count && $signed(heap_keys[best]) < $signed(heap_keys[lft]))
						best = lft;
					if (rgt < heap_count && $signed(heap_keys[best]) < $signed(heap_keys[rgt]))
						best = rgt;
					if (best == pos)
						break;
					swap_keys(pos, best);
					pos = best;
				end
			end
		end
		r.occupancy = heap_count[mhpq_pkg::OCC_W-1:0];
		return r;
	endfunction

	// pick a key: full range, narrow bands for ties, or the extremes
	function automatic logic [KEY_W-1:0] draw_key();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom;
		else if (pick < 6)
			return KEY_W'($signed($urandom_range(0, 8)) - 4);
		else if (pick < 8)
			return KEY_W'($signed($urandom_range(0, 511)) - 256);
		else begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
	endfunction

	function automatic void queue_op(input logic cmd, input logic [KEY_W-1:0] key,
	                                 input bit drain_first);
		heap_op_t op;
		op.cmd = cmd;
		op.key = key;
		op.drain_first = drain_first;
		pending_ops.push_back(op);
	endfunction

	// driver: present pending transactions in bursts with random gaps
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		logic               next_start;
		logic               next_cmd;
		logic [KEY_W-1:0]   next_key;
		next_start = 1'b0;
		next_cmd   = command;
		next_key   = item_value;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(heap_apply(command, item_value));
				void'(pending_ops.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
				end
			end
			if (start && busy) begin
				// hold the offered transaction until it is taken
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_ops.size() != 0) begin
				if (!pending_ops[0].drain_first || (expected_results.size() == 0 && !busy)) begin
					next_start = 1'b1;
					next_cmd   = pending_ops[0].cmd;
					next_key   = pending_ops[0].key;
				end
			end
		end
		start      <= next_start;
		command    <= next_cmd;
		item_value <= next_key;
	end

	// monitor: check each done strobe against the oldest prediction
	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d value %0d occupancy %0d",
				         $time, status, result_value, occupancy);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
					         $time, exp_r.status, status);
					error_count++;
				end
				if (result_value !== exp_r.value) begin
					$display("%0t: result_value mismatch, expected %0d, actual %0d",
					         $time, $signed(exp_r.value), result_value);
					error_count++;
				end
				if (occupancy !== exp_r.occupancy) begin
					$display("%0t: occupancy mismatch, expected %0d, actual %0d",
					         $time, exp_r.occupancy, occupancy);
					error_count++;
				end
			end
		end
	end

	// watchdog: count cycles with no transaction and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT)
			timed_out <= 1'b1;
	end

	initial begin
		int unsigned issued;
		int unsigned phase_len;
		int unsigned insert_pct;
		int unsigned k;

		// directed: underflow, extremes, equal keys, drain to empty
		queue_op(mhpq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h8000_0000, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0000, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h0000_0001, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b0);
		for (k = 0; k < 10; k++)
			queue_op(mhpq_pkg::CMD_REMOVE, $urandom, 1'b0);
		queue_op(mhpq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h8000_0000, 1'b0);
		queue_op(mhpq_pkg::CMD_INSERT, 32'h8000_0000, 1'b0);
		queue_op(mhpq_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 1'b0);

		// fill past capacity, then empty past zero, after a full drain
		for (k = 0; k < 70; k++)
			queue_op(mhpq_pkg::CMD_INSERT, draw_key(), k == 0);
		for (k = 0; k < 70; k++)
			queue_op(mhpq_pkg::CMD_REMOVE, $urandom, 1'b0);

		// random phases with an insert or removal bias
		issued = 164;
		while (issued < RANDOM_OPS) begin
			phase_len = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0: insert_pct = 90;
				1: insert_pct = 10;
				2: insert_pct = 50;
				default: insert_pct = 65;
			endcase
			for (k = 0; k < phase_len; k++) begin
				queue_op(($urandom_range(1, 100) <= insert_pct) ?
				         mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_REMOVE,
				         draw_key(), $urandom_range(0, 99) == 0);
			end
			issued += phase_len;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (pending_ops.size() != 0 || expected_results.size() != 0))
			@(posedge clk);
		if (!timed_out)
			repeat (TAIL_CYCLES) @(posedge clk);

		if (!timed_out && error_count == 0) begin
			$display("** max_heap_priority_queue: PASSED **");
		end else begin
			$display("** max_heap_priority_queue: FAILED **");
		end
		$finish;
	end

endmodule

// ===== max_heap_priority_queue.f =====
hdl/mhpq_pkg.sv
hdl/mhpq_store.sv
hdl/max_heap_priority_queue.sv
tb/tb.sv
